/* hw/rtl/phmt_pkg.sv */
`timescale 1ns / 1ps

package phmt_pkg;

  // Slots in one table, and the width of a stored handle.
  localparam int unsigned ENTRIES      = 64;
  localparam int unsigned HANDLE_WIDTH = 16;

  localparam int unsigned TOTAL_SLOTS = 2 * ENTRIES;
  localparam int unsigned SLOT_W      = $clog2(ENTRIES);
  localparam int unsigned ADDR_W      = $clog2(TOTAL_SLOTS);

  // Fixed widths of the ports.
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned PORT_W      = 16;
  localparam int unsigned SLOT_PORT_W = 6;

  typedef logic [HANDLE_WIDTH-1:0] handle_t;
  typedef logic [SLOT_W-1:0]       slot_idx_t;
  typedef logic [ADDR_W-1:0]       addr_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIND   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_GET    = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_READ
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the request and the registered match vectors
    logic commit;    // apply table updates and load the result register
    logic rd_issue;  // start the value read for a successful get
    logic rd_load;   // load the result register from the value read
  } phmt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic get_hit;   // the pending request is a get whose key is present
  } phmt_stat_t;

  function automatic handle_t to_handle(input logic [PORT_W-1:0] p);
    logic [HANDLE_WIDTH+PORT_W-1:0] w;
    w = {{HANDLE_WIDTH{1'b0}}, p};
    return w[HANDLE_WIDTH-1:0];
  endfunction

  function automatic logic [PORT_W-1:0] to_port(input handle_t h);
    logic [HANDLE_WIDTH+PORT_W-1:0] w;
    w = {{PORT_W{1'b0}}, h};
    return w[PORT_W-1:0];
  endfunction

  function automatic logic [SLOT_PORT_W-1:0] to_slot_port(input slot_idx_t s);
    logic [SLOT_W+SLOT_PORT_W-1:0] w;
    w = {{SLOT_PORT_W{1'b0}}, s};
    return w[SLOT_PORT_W-1:0];
  endfunction

endpackage

/* hw/rtl/phmt_ram.sv */
`timescale 1ns / 1ps

module phmt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/phmt_datapath.sv */
`timescale 1ns / 1ps

module phmt_datapath
  import phmt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  phmt_cmd_t              ctrl_i,
  output phmt_stat_t             stat_o,
  input  logic [CMD_W-1:0]       command_i,
  input  logic                   direction_i,
  input  logic [PORT_W-1:0]      lookup_key_i,
  input  logic [PORT_W-1:0]      new_value_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [SLOT_PORT_W-1:0] slot_o,
  output logic [PORT_W-1:0]      read_value_o
);

  localparam addr_t UPPER_BASE = ADDR_W'(ENTRIES);

  // Key cells and valid bits; values live in the RAM.
  handle_t                  key_q [TOTAL_SLOTS];
  logic [TOTAL_SLOTS-1:0]   valid_q;

  // Latched request.
  cmd_e                     cmd_q;
  logic                     dir_q;
  handle_t                  key_req_q;
  handle_t                  val_req_q;
  logic [ENTRIES-1:0]       hit_vec_q, hit_vec_d;
  logic [ENTRIES-1:0]       free_vec_q, free_vec_d;

  // Result register.
  status_e                  status_q, status_d;
  slot_idx_t                slot_q, slot_d;
  logic [PORT_W-1:0]        rval_q;

  // Priority encode and update decisions.
  logic                     hit_any, free_any;
  slot_idx_t                hit_idx, free_idx;
  addr_t                    hit_addr, free_addr;
  logic                     key_we, val_we, valid_set, valid_clr;
  addr_t                    wr_addr;
  handle_t                  ram_rdata;

  function automatic slot_idx_t top_index(input logic [ENTRIES-1:0] v);
    slot_idx_t r;
    r = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (v[i]) begin
        r = SLOT_W'(i);
      end
    end
    return r;
  endfunction

  // Every cell of the chosen table compares against the incoming key.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      logic    lane_valid;
      handle_t lane_key;
      lane_valid    = direction_i ? valid_q[ENTRIES + i] : valid_q[i];
      lane_key      = direction_i ? key_q[ENTRIES + i] : key_q[i];
      hit_vec_d[i]  = lane_valid && (lane_key == to_handle(lookup_key_i));
      free_vec_d[i] = !lane_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q      <= cmd_e'(command_i);
      dir_q      <= direction_i;
      key_req_q  <= to_handle(lookup_key_i);
      val_req_q  <= to_handle(new_value_i);
      hit_vec_q  <= hit_vec_d;
      free_vec_q <= free_vec_d;
    end
  end

  assign hit_any   = |hit_vec_q;
  assign free_any  = |free_vec_q;
  assign hit_idx   = top_index(hit_vec_q);
  assign free_idx  = top_index(free_vec_q);
  assign hit_addr  = (dir_q ? UPPER_BASE : '0) + ADDR_W'(hit_idx);
  assign free_addr = (dir_q ? UPPER_BASE : '0) + ADDR_W'(free_idx);

  assign stat_o.get_hit = (cmd_q == CMD_GET) && hit_any;

  always_comb begin
    status_d  = STAT_MISS;
    slot_d    = '0;
    key_we    = 1'b0;
    val_we    = 1'b0;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    wr_addr   = hit_addr;
    case (cmd_q)
      CMD_FIND: begin
        if (hit_any) begin
          status_d = STAT_OK;
          slot_d   = hit_idx;
        end
      end
      CMD_INSERT: begin
        if (hit_any) begin
          status_d = STAT_OK;
          slot_d   = hit_idx;
          val_we   = 1'b1;
        end else if (free_any) begin
          status_d  = STAT_OK;
          slot_d    = free_idx;
          wr_addr   = free_addr;
          key_we    = 1'b1;
          val_we    = 1'b1;
          valid_set = 1'b1;
        end else begin
          status_d = STAT_FULL;
        end
      end
      CMD_REMOVE: begin
        if (hit_any) begin
          status_d  = STAT_OK;
          slot_d    = hit_idx;
          valid_clr = 1'b1;
        end
      end
      default: begin
        // A get only commits here when its key is absent.
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TOTAL_SLOTS; i++) begin
      if (ctrl_i.commit && key_we && (wr_addr == ADDR_W'(i))) begin
        key_q[i] <= key_req_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctrl_i.commit) begin
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
        if (wr_addr == ADDR_W'(i)) begin
          if (valid_set) begin
            valid_q[i] <= 1'b1;
          end else if (valid_clr) begin
            valid_q[i] <= 1'b0;
          end
        end
      end
    end
  end

  phmt_ram #(
    .WIDTH (HANDLE_WIDTH),
    .DEPTH (TOTAL_SLOTS)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.commit && val_we),
    .waddr_i (wr_addr),
    .wdata_i (val_req_q),
    .re_i    (ctrl_i.rd_issue),
    .raddr_i (hit_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      rval_q   <= '0;
    end else if (ctrl_i.rd_load) begin
      status_q <= STAT_OK;
      slot_q   <= hit_idx;
      rval_q   <= to_port(ram_rdata);
    end
  end

  assign status_o     = status_q;
  assign slot_o       = to_slot_port(slot_q);
  assign read_value_o = rval_q;

endmodule

/* hw/rtl/phmt_ctrl.sv */
`timescale 1ns / 1ps

module phmt_ctrl
  import phmt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  phmt_stat_t stat_i,
  output phmt_cmd_t  ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   load_ok;

  // The result register may be loaded once the previous result has left.
  assign load_ok = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.get_hit) begin
          state_d = S_READ;
        end else if (load_ok) begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        if (load_ok) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o     = 1'b1;
        ctrl_o.capture = in_valid_i;
      end
      S_DECIDE: begin
        ctrl_o.rd_issue = stat_i.get_hit;
        ctrl_o.commit   = !stat_i.get_hit && load_ok;
      end
      S_READ: begin
        ctrl_o.rd_load = load_ok;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.commit || ctrl_o.rd_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/paired_handle_map_table_unit.sv */
`timescale 1ns / 1ps

// Two independent fully associative handle tables, picked per request by the
// direction bit, each with ENTRIES slots of key, value and valid bit. A request
// transfer carries a find, insert, get or remove; every request gives exactly
// one result transfer with a status, the slot and, for a get, the stored value.
// Searches always pick the highest-numbered matching slot, and an insert of a
// new key takes the highest-numbered free slot. The block works on one request
// at a time: every key cell of the chosen table is compared in parallel and
// the match vector is registered as the transfer is taken; a find, insert or
// remove then does its priority encoding and table update in the decide state,
// while a get issues a registered read of the value RAM there and loads its
// result in the read state. A new request may be taken while the previous
// result still waits in the output register; if the output side stalls, the
// block holds its next result until the register is free. All valid bits
// clear at reset, so no clearing pass is needed and requests are taken from
// the first cycle after reset.
module paired_handle_map_table_unit
  import phmt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CMD_W-1:0]       command_i,
  input  logic                   direction_i,
  input  logic [PORT_W-1:0]      lookup_key_i,
  input  logic [PORT_W-1:0]      new_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [SLOT_PORT_W-1:0] slot_o,
  output logic [PORT_W-1:0]      read_value_o
);

  phmt_cmd_t  ctrl;
  phmt_stat_t stat;

  // Sequencing of each request and ownership of the result valid flag.
  phmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // Key cells, valid bits, value RAM and the result register.
  phmt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .command_i    (command_i),
    .direction_i  (direction_i),
    .lookup_key_i (lookup_key_i),
    .new_value_i  (new_value_i),
    .status_o     (status_o),
    .slot_o       (slot_o),
    .read_value_o (read_value_o)
  );

endmodule

/* hw/rtl/phmt_checker.sv */
`timescale 1ns / 1ps

module phmt_checker
  import phmt_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic [CMD_W-1:0]       command_i,
  input logic                   direction_i,
  input logic [PORT_W-1:0]      lookup_key_i,
  input logic [PORT_W-1:0]      new_value_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [STATUS_W-1:0]    status_o,
  input logic [SLOT_PORT_W-1:0] slot_o,
  input logic [PORT_W-1:0]      read_value_o
);

  // A waiting request is held unchanged by its source until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(command_i)
      && $stable(direction_i) && $stable(lookup_key_i) && $stable(new_value_i))
    else $error("request changed while waiting");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(slot_o) && $stable(read_value_o))
    else $error("result changed while stalled");

  // Only one request is in flight, so the input is closed once a transfer is taken.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

  // A failed request reports slot zero and no value.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> (slot_o == '0) && (read_value_o == '0))
    else $error("failed request carries slot or value");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STAT_OK) || (status_o == STAT_MISS)
      || (status_o == STAT_FULL))
    else $error("undefined status code");

endmodule

bind paired_handle_map_table_unit phmt_checker u_phmt_checker (.*);
